/* hdl/ucl_pkg.sv */
// Shared types, constants and sizes of the serial command line parser.
// Used by ucl_ctrl, ucl_datapath and uart_command_line_parser.
package ucl_pkg;

	localparam int LINE_BYTES   = 32;
	localparam int LEDS_PER_ROW = 5;
	localparam int PATTERN_ROWS = 16;
	localparam int PAT_ENTRIES  = PATTERN_ROWS * LEDS_PER_ROW;

	localparam int LEN_W   = $clog2(LINE_BYTES + 1);
	localparam int POS_W   = $clog2(LINE_BYTES);
	localparam int PADDR_W = $clog2(PAT_ENTRIES);
	localparam int ROW_W   = $clog2(PATTERN_ROWS);
	localparam int K_W     = $clog2(LEDS_PER_ROW + 1);
	localparam int SEQ_W   = $clog2(8 + 3 * LEDS_PER_ROW);
	localparam int CNT_W   = (SEQ_W > LEN_W) ? SEQ_W : LEN_W;
	localparam int ROWB_W  = 8 * LEDS_PER_ROW;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_P     = 8'h50;

	localparam logic [15:0] PERIOD_MIN = 16'd10;
	localparam logic [15:0] PERIOD_MAX = 16'd10000;
	localparam logic [7:0]  SIM_MIN    = 8'd50;

	typedef enum logic [2:0] {
		C_IDLE,
		C_CHECK,
		C_PWR,
		C_FETCH,
		C_EMIT
	} state_t;

	typedef enum logic [1:0] {
		K_NONE,
		K_RB,
		K_PAT,
		K_ERR
	} kind_t;

	typedef enum logic [2:0] {
		E_DELIM,
		E_VALUE,
		E_LIMIT,
		E_INDEX,
		E_MODE,
		E_COMMAND,
		E_COMMA
	} err_t;

	typedef enum logic [1:0] {
		SEG_ECHO,
		SEG_PRE,
		SEG_BODY
	} seg_t;

	typedef struct packed {
		logic accept;
		logic check;
		logic pwr_step;
		logic fetch_step;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic dec_go;
		logic to_pwr;
		logic to_fetch;
		logic pwr_ok;
		logic pwr_fail;
		logic fetch_done;
		logic slot_free;
		logic last;
	} ctl_sts_t;

endpackage

/* hdl/ucl_ctrl.sv */
// Sequencing state machine of the command line parser.
// Depends on ucl_pkg; drives ucl_datapath through ctl_cmd_t.
module ucl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output ucl_pkg::ctl_cmd_t cmd,
	input  ucl_pkg::ctl_sts_t sts
);
	import ucl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: begin
				if (in_valid) begin
					state_d = sts.dec_go ? C_CHECK : C_EMIT;
				end
			end
			C_CHECK: begin
				if (sts.to_pwr) begin
					state_d = C_PWR;
				end else if (sts.to_fetch) begin
					state_d = C_FETCH;
				end else begin
					state_d = C_EMIT;
				end
			end
			C_PWR: begin
				if (sts.pwr_ok) begin
					state_d = C_FETCH;
				end else if (sts.pwr_fail) begin
					state_d = C_EMIT;
				end
			end
			C_FETCH: begin
				if (sts.fetch_done) begin
					state_d = C_EMIT;
				end
			end
			C_EMIT: begin
				if (sts.slot_free && sts.last) begin
					state_d = C_IDLE;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == C_IDLE) && in_valid;
		cmd.check      = (state_q == C_CHECK);
		cmd.pwr_step   = (state_q == C_PWR);
		cmd.fetch_step = (state_q == C_FETCH);
		cmd.emit       = (state_q == C_EMIT);
		in_stall       = (state_q != C_IDLE);
	end

endmodule

/* hdl/ucl_datapath.sv */
// Line store, settings registers, pattern memory and reply byte generator.
// Depends on ucl_pkg; commanded by ucl_ctrl.
module ucl_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ucl_pkg::ctl_cmd_t cmd,
	output ucl_pkg::ctl_sts_t sts,
	input  logic [7:0]        in_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              last_of_run,
	output logic [13:0]       flash_period,
	output logic [13:0]       blank_period,
	output logic [13:0]       interval_period,
	output logic [7:0]        sim_period
);
	import ucl_pkg::*;

	function automatic logic [4:0] hexval(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd16;
		if (c inside {[8'h30:8'h39]}) begin
			r = 5'(c - 8'h30);
		end else if (c inside {[8'h41:8'h46]}) begin
			r = 5'(c - 8'h37);
		end else if (c inside {[8'h61:8'h66]}) begin
			r = 5'(c - 8'h57);
		end
		return r;
	endfunction

	function automatic logic [7:0] nib_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + 8'(n)) : (8'h37 + 8'(n));
	endfunction

	function automatic logic [71:0] err_word(input err_t e);
		logic [71:0] w;
		case (e)
			E_DELIM:   w = "delimiter";
			E_VALUE:   w = "value";
			E_LIMIT:   w = "limit";
			E_INDEX:   w = "index";
			E_MODE:    w = "mode";
			E_COMMAND: w = "command";
			E_COMMA:   w = "comma";
			default:   w = "command";
		endcase
		return w;
	endfunction

	function automatic logic [3:0] err_len(input err_t e);
		logic [3:0] n;
		case (e)
			E_DELIM:   n = 4'd9;
			E_MODE:    n = 4'd4;
			E_COMMAND: n = 4'd7;
			default:   n = 4'd5;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] err_byte(input err_t e, input logic [SEQ_W-1:0] i);
		logic [71:0] w;
		logic [3:0]  n;
		logic [7:0]  b;
		logic [6:0]  sh;
		w = err_word(e);
		n = err_len(e);
		b = CH_LF;
		sh = '0;
		if (i == SEQ_W'(0)) begin
			b = CH_E;
		end else if (i == SEQ_W'(1)) begin
			b = CH_COLON;
		end else if (i < SEQ_W'(n) + SEQ_W'(2)) begin
			sh = 7'((SEQ_W'(n) + SEQ_W'(1) - i) * 8);
			b = 8'(w >> sh);
		end else if (i == SEQ_W'(n) + SEQ_W'(2)) begin
			b = CH_CR;
		end
		return b;
	endfunction

	logic [7:0]       line_q [LINE_BYTES];
	logic [LEN_W-1:0] len_q;
	logic [13:0]      flash_q;
	logic [13:0]      blank_q;
	logic [13:0]      intv_q;
	logic [7:0]       sim_q;

	logic [7:0]             pat_mem [PAT_ENTRIES];
	logic [PAT_ENTRIES-1:0] pat_vld_q;
	logic [7:0]             rd_q;
	logic                   rv_q;

	logic [7:0]        ch_q;
	kind_t             kind_q;
	err_t              err_q;
	logic              pre_q;
	logic [7:0]        cmd_q;
	logic [15:0]       val_q;
	logic [2:0]        nd_q;
	logic [ROW_W-1:0]  idx_q;
	logic [PADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  pos_q;
	logic [1:0]        ph_q;
	logic [K_W-1:0]    k_q;
	logic [K_W-1:0]    fk_q;
	logic [4:0]        hi_q;
	logic [4:0]        lo_q;
	logic [ROWB_W-1:0] row_q;
	seg_t              seg_q;
	logic [SEQ_W-1:0]  bi_q;

	logic              out_vld_q;
	logic [7:0]        out_byte_q;
	logic              last_q;
	logic [13:0]       oflash_q;
	logic [13:0]       oblank_q;
	logic [13:0]       ointv_q;
	logic [7:0]        osim_q;

	// Decode of the fixed line positions.
	logic [4:0]  h3, h4, h5, h6;
	logic [15:0] pv;
	logic [7:0]  sv;
	logic        rd_mode, mode_ok, delim2, delim4, pok, sok, plim, slim;
	kind_t       d_kind;
	err_t        d_err;
	logic [15:0] d_val;
	logic [2:0]  d_nd;
	logic        wr_f, wr_b, wr_i, wr_s, d_pwr, d_fetch;

	always_comb begin
		h3      = hexval(line_q[3]);
		h4      = hexval(line_q[4]);
		h5      = hexval(line_q[5]);
		h6      = hexval(line_q[6]);
		pv      = {h3[3:0], h4[3:0], h5[3:0], h6[3:0]};
		sv      = {h3[3:0], h4[3:0]};
		pok     = !h3[4] && !h4[4] && !h5[4] && !h6[4];
		sok     = !h3[4] && !h4[4];
		plim    = (pv >= PERIOD_MIN) && (pv <= PERIOD_MAX);
		slim    = (sv >= SIM_MIN);
		rd_mode = (line_q[1] == CH_R);
		mode_ok = rd_mode || (line_q[1] == CH_W);
		delim2  = (line_q[2] == CH_COLON);
		delim4  = (line_q[4] == CH_COLON);
		d_kind  = K_NONE;
		d_err   = E_COMMAND;
		d_val   = '0;
		d_nd    = 3'd4;
		wr_f    = 1'b0;
		wr_b    = 1'b0;
		wr_i    = 1'b0;
		wr_s    = 1'b0;
		d_pwr   = 1'b0;
		d_fetch = 1'b0;
		if (!mode_ok) begin
			d_kind = K_ERR;
			d_err  = E_MODE;
		end else begin
			case (line_q[0])
				CH_H: begin
					d_kind = K_NONE;
				end
				CH_F, CH_B, CH_I: begin
					if (line_q[0] == CH_F) begin
						d_val = {2'b00, flash_q};
					end else if (line_q[0] == CH_B) begin
						d_val = {2'b00, blank_q};
					end else begin
						d_val = {2'b00, intv_q};
					end
					d_kind = K_RB;
					if (!rd_mode) begin
						if (!delim2) begin
							d_kind = K_ERR;
							d_err  = E_DELIM;
						end else if (!pok) begin
							d_kind = K_ERR;
							d_err  = E_VALUE;
						end else if (!plim) begin
							d_kind = K_ERR;
							d_err  = E_LIMIT;
						end else begin
							d_val = pv;
							wr_f  = (line_q[0] == CH_F);
							wr_b  = (line_q[0] == CH_B);
							wr_i  = (line_q[0] == CH_I);
						end
					end
				end
				CH_S: begin
					d_nd   = 3'd2;
					d_val  = {8'h00, sim_q};
					d_kind = K_RB;
					if (!rd_mode) begin
						if (!delim2) begin
							d_kind = K_ERR;
							d_err  = E_DELIM;
						end else if (!sok) begin
							d_kind = K_ERR;
							d_err  = E_VALUE;
						end else if (!slim) begin
							d_kind = K_ERR;
							d_err  = E_LIMIT;
						end else begin
							d_val = {8'h00, sv};
							wr_s  = 1'b1;
						end
					end
				end
				CH_P: begin
					if (!delim2 || (!rd_mode && !delim4)) begin
						d_kind = K_ERR;
						d_err  = E_DELIM;
					end else if (h3[4]) begin
						d_kind = K_ERR;
						d_err  = E_INDEX;
					end else begin
						d_kind  = K_PAT;
						d_pwr   = !rd_mode;
						d_fetch = rd_mode;
					end
				end
				default: begin
					d_kind = K_ERR;
					d_err  = E_COMMAND;
				end
			endcase
		end
	end

	// Pattern write scan reads one line byte per cycle.
	logic [7:0]       scan_b;
	logic             ent_ok;
	logic [PADDR_W-1:0] waddr;
	logic [PADDR_W-1:0] faddr;

	always_comb begin
		scan_b = 8'h00;
		if (pos_q < CNT_W'(LINE_BYTES)) begin
			scan_b = line_q[pos_q[POS_W-1:0]];
		end
		ent_ok = !hi_q[4] && !lo_q[4];
		waddr  = base_q + PADDR_W'(k_q);
		faddr  = base_q + PADDR_W'(fk_q);
	end

	// Reply sequence.
	logic [SEQ_W-1:0] body_len;
	logic [7:0]       body_b;
	logic [7:0]       cur_b;
	logic             cur_last;
	logic [3:0]       rb_nib;
	logic [4:0]       rb_sh;

	always_comb begin
		case (kind_q)
			K_RB:    body_len = SEQ_W'(nd_q) + SEQ_W'(5);
			K_PAT:   body_len = SEQ_W'(7 + 3 * LEDS_PER_ROW);
			K_ERR:   body_len = SEQ_W'(err_len(err_q)) + SEQ_W'(4);
			default: body_len = '0;
		endcase
		rb_sh  = 5'((SEQ_W'(nd_q) + SEQ_W'(2) - bi_q) * 4);
		rb_nib = 4'(val_q >> rb_sh);
		body_b = CH_LF;
		case (kind_q)
			K_RB: begin
				if (bi_q == SEQ_W'(0)) begin
					body_b = cmd_q;
				end else if (bi_q == SEQ_W'(1)) begin
					body_b = CH_R;
				end else if (bi_q == SEQ_W'(2)) begin
					body_b = CH_COLON;
				end else if (bi_q < SEQ_W'(nd_q) + SEQ_W'(3)) begin
					body_b = nib_char(rb_nib);
				end else if (bi_q == SEQ_W'(nd_q) + SEQ_W'(3)) begin
					body_b = CH_CR;
				end
			end
			K_PAT: begin
				if (bi_q == SEQ_W'(0)) begin
					body_b = CH_P;
				end else if (bi_q == SEQ_W'(1)) begin
					body_b = CH_R;
				end else if (bi_q == SEQ_W'(2) || bi_q == SEQ_W'(4)) begin
					body_b = CH_COLON;
				end else if (bi_q == SEQ_W'(3)) begin
					body_b = nib_char(4'(idx_q));
				end else if (bi_q == SEQ_W'(5 + 3 * LEDS_PER_ROW)) begin
					body_b = CH_CR;
				end
				for (int k = 0; k < LEDS_PER_ROW; k++) begin
					if (bi_q == SEQ_W'(5 + 3 * k)) begin
						body_b = nib_char(row_q[(LEDS_PER_ROW - 1 - k) * 8 + 4 +: 4]);
					end
					if (bi_q == SEQ_W'(6 + 3 * k)) begin
						body_b = nib_char(row_q[(LEDS_PER_ROW - 1 - k) * 8 +: 4]);
					end
					if (bi_q == SEQ_W'(7 + 3 * k)) begin
						body_b = CH_COMMA;
					end
				end
			end
			K_ERR: begin
				body_b = err_byte(err_q, bi_q);
			end
			default: begin
				body_b = CH_LF;
			end
		endcase
		case (seg_q)
			SEG_ECHO: begin
				cur_b    = ch_q;
				cur_last = !pre_q && (body_len == '0);
			end
			SEG_PRE: begin
				cur_b    = err_byte(E_VALUE, bi_q);
				cur_last = (bi_q == SEQ_W'(8)) && (body_len == '0);
			end
			default: begin
				cur_b    = body_b;
				cur_last = (bi_q == body_len - SEQ_W'(1));
			end
		endcase
	end

	logic slot_free;
	logic do_emit;

	always_comb begin
		slot_free      = !out_vld_q || !out_stall;
		do_emit        = cmd.emit && slot_free;
		sts            = '0;
		sts.dec_go     = (in_byte == CH_CR) && (len_q != '0);
		sts.to_pwr     = d_pwr;
		sts.to_fetch   = d_fetch;
		sts.pwr_fail   = (ph_q == 2'd2) && ((scan_b != CH_COMMA) || !ent_ok);
		sts.pwr_ok     = (ph_q == 2'd2) && (scan_b == CH_COMMA) && ent_ok &&
			(k_q == K_W'(LEDS_PER_ROW - 1));
		sts.fetch_done = (fk_q == K_W'(LEDS_PER_ROW));
		sts.slot_free  = slot_free;
		sts.last       = cur_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_BYTES; i++) begin
				line_q[i] <= 8'h00;
			end
			len_q   <= '0;
			flash_q <= '0;
			blank_q <= '0;
			intv_q  <= '0;
			sim_q   <= '0;
		end else begin
			if (cmd.accept) begin
				if (len_q < LEN_W'(LINE_BYTES)) begin
					line_q[len_q[POS_W-1:0]] <= in_byte;
				end
				if (in_byte == CH_CR) begin
					len_q <= '0;
				end else if (len_q < LEN_W'(LINE_BYTES)) begin
					len_q <= len_q + LEN_W'(1);
				end
			end
			if (cmd.check) begin
				if (wr_f) flash_q <= pv[13:0];
				if (wr_b) blank_q <= pv[13:0];
				if (wr_i) intv_q <= pv[13:0];
				if (wr_s) sim_q <= sv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_vld_q <= '0;
		end else if (cmd.pwr_step && (ph_q == 2'd2) && (scan_b == CH_COMMA) && ent_ok) begin
			pat_vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pwr_step && (ph_q == 2'd2) && (scan_b == CH_COMMA) && ent_ok) begin
			pat_mem[waddr] <= {hi_q[3:0], lo_q[3:0]};
		end
		if (cmd.fetch_step && (fk_q < K_W'(LEDS_PER_ROW))) begin
			rd_q <= pat_mem[faddr];
			rv_q <= pat_vld_q[faddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= K_NONE;
			err_q  <= E_COMMAND;
			pre_q  <= 1'b0;
			seg_q  <= SEG_ECHO;
			bi_q   <= '0;
			ph_q   <= '0;
			k_q    <= '0;
			fk_q   <= '0;
		end else begin
			if (cmd.accept) begin
				kind_q <= K_NONE;
				pre_q  <= 1'b0;
				seg_q  <= SEG_ECHO;
				bi_q   <= '0;
			end
			if (cmd.check) begin
				kind_q <= d_kind;
				err_q  <= d_err;
				ph_q   <= '0;
				k_q    <= '0;
				fk_q   <= '0;
			end
			if (cmd.pwr_step) begin
				ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
				if (ph_q == 2'd2) begin
					if (scan_b != CH_COMMA) begin
						kind_q <= K_ERR;
						err_q  <= E_COMMA;
						pre_q  <= !ent_ok;
					end else if (!ent_ok) begin
						kind_q <= K_ERR;
						err_q  <= E_VALUE;
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
			end
			if (cmd.fetch_step) begin
				fk_q <= fk_q + K_W'(1);
			end
			if (do_emit) begin
				if (seg_q == SEG_ECHO) begin
					seg_q <= pre_q ? SEG_PRE : SEG_BODY;
					bi_q  <= '0;
				end else if ((seg_q == SEG_PRE) && (bi_q == SEQ_W'(8))) begin
					seg_q <= SEG_BODY;
					bi_q  <= '0;
				end else begin
					bi_q <= bi_q + SEQ_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q <= in_byte;
		end
		if (cmd.check) begin
			cmd_q  <= line_q[0];
			val_q  <= d_val;
			nd_q   <= d_nd;
			idx_q  <= h3[ROW_W-1:0];
			base_q <= PADDR_W'(h3[3:0]) * PADDR_W'(LEDS_PER_ROW);
			pos_q  <= CNT_W'(5);
		end
		if (cmd.pwr_step) begin
			pos_q <= pos_q + CNT_W'(1);
			if (ph_q == 2'd0) begin
				hi_q <= hexval(scan_b);
			end
			if (ph_q == 2'd1) begin
				lo_q <= hexval(scan_b);
			end
		end
		if (cmd.fetch_step && (fk_q != '0)) begin
			row_q <= {row_q[ROWB_W-1:0] << 8} | ROWB_W'(rv_q ? rd_q : 8'h00);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (do_emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			out_byte_q <= cur_b;
			last_q     <= cur_last;
			oflash_q   <= flash_q;
			oblank_q   <= blank_q;
			ointv_q    <= intv_q;
			osim_q     <= sim_q;
		end
	end

	assign out_valid       = out_vld_q;
	assign out_byte        = out_byte_q;
	assign last_of_run     = last_q;
	assign flash_period    = oflash_q;
	assign blank_period    = oblank_q;
	assign interval_period = ointv_q;
	assign sim_period      = osim_q;

endmodule

/* hdl/uart_command_line_parser.sv */
// Top level of the serial command line parser.
// Depends on ucl_pkg, ucl_ctrl and ucl_datapath.
//
// The input channel takes one received character per transfer (in_valid,
// in_stall, in_byte). The output channel gives the reply bytes, one per
// transfer: first the echo of the character, then, after a CR that closes a
// line of two or more bytes, the readback or error text of that line, if any.
// last_of_run marks the final byte caused by one input character, and the
// four period fields carry the settings as they stand after that character.
// One character is handled at a time: in_stall is high from the transfer
// until its last reply byte has been loaded into the output register.
// A plain character gives its echo alone. A decoded line goes through a decode
// step, a pattern scan for a pattern write, pattern memory reads for a
// pattern reply, and then one reply byte per cycle (at most 23) while the
// receiver does not stall.
// When out_stall is high the output register holds its byte and generation
// waits. Reset clears the line store, all settings and the pattern valid flags.
module uart_command_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic [13:0] flash_period,
	output logic [13:0] blank_period,
	output logic [13:0] interval_period,
	output logic [7:0]  sim_period
);
	import ucl_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ucl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	ucl_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_byte         (in_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.last_of_run     (last_of_run),
		.flash_period    (flash_period),
		.blank_period    (blank_period),
		.interval_period (interval_period),
		.sim_period      (sim_period)
	);

endmodule
